// File: rtl/sfr_pkg.sv
`default_nettype none
package sfr_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned HDR_BYTES = 4;

  localparam logic [7:0] HDR_FIRST = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT = 8'hF1;

  typedef enum logic [2:0] {
    PH_WAIT_AA,
    PH_WAIT_AF,
    PH_WAIT_FUNC,
    PH_WAIT_LEN,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_DUMP
  } phase_t;

  typedef struct packed {
    logic             go;
    logic [IDX_W-1:0] last_idx;
  } dump_cmd_t;

endpackage
`default_nettype wire

// File: rtl/sfr_ram.sv
`default_nettype none
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 54
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/sfr_dump.sv
`default_nettype none
module sfr_dump #(
  parameter int unsigned AW = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sfr_pkg::dump_cmd_t      cmd,
  input  wire logic                    out_ready,
  output logic                         re,
  output logic [AW-1:0]                raddr,
  output logic                         out_valid,
  output logic [sfr_pkg::IDX_W-1:0]    out_byte_index,
  output logic                         out_last_byte,
  output logic                         done
);
  import sfr_pkg::*;

  logic [IDX_W-1:0] next_idx_r, next_idx_nxt;
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             issued_all_r, issued_all_nxt;
  logic             active_r, active_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic             issue;

  assign issue = active_r && !issued_all_r && (!out_valid_r || out_ready);
  assign re = issue;
  assign raddr = next_idx_r[AW-1:0];
  assign done = out_valid_r && out_ready && out_last_r;

  always_comb begin
    next_idx_nxt = next_idx_r;
    last_idx_nxt = last_idx_r;
    out_idx_nxt = out_idx_r;
    issued_all_nxt = issued_all_r;
    active_nxt = active_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt = out_last_r;
    if (cmd.go) begin
      next_idx_nxt = '0;
      last_idx_nxt = cmd.last_idx;
      issued_all_nxt = 1'b0;
      active_nxt = 1'b1;
    end else if (issue) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt = next_idx_r;
      out_last_nxt = (next_idx_r == last_idx_r);
      next_idx_nxt = next_idx_r + IDX_W'(1);
      issued_all_nxt = (next_idx_r == last_idx_r);
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
      if (out_last_r) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      out_valid_r <= 1'b0;
      issued_all_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      out_valid_r <= out_valid_nxt;
      issued_all_r <= issued_all_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_idx_r <= next_idx_nxt;
    last_idx_r <= last_idx_nxt;
    out_idx_r <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte_index = out_idx_r;
  assign out_last_byte = out_last_r;

endmodule
`default_nettype wire

// File: rtl/serial_frame_receiver.sv
`default_nettype none
// Serial frame receiver: takes received bytes one beat at a time and stores
// frames of the form 0xAA, 0xAF, function (1..240), length L (0..MAX_PAYLOAD),
// L payload bytes and one unchecked trailer byte in a single frame RAM.
// Bytes that do not fit while waiting for a header, function or length byte
// are dropped. Input is ready in every phase through the trailer. After the
// trailer beat the block stops accepting input and reads the frame back out
// of the RAM, L + 5 output beats with byte_index from 0 and last_byte on the
// trailer; the RAM read is registered, then without backpressure the readout
// gives one beat per cycle, set by the RAM's single read port. Input is
// accepted again in the cycle after the last beat is taken.
module serial_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 49
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic [5:0]      out_byte_index,
  output logic            out_last_byte
);
  import sfr_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_PAYLOAD + HDR_BYTES + 1;
  localparam int unsigned AW = $clog2(STORE_DEPTH);

  phase_t          phase_r, phase_nxt;
  logic [AW-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   pcnt_r, pcnt_nxt;
  logic            acc;
  logic [7:0]      b;
  logic [AW-1:0]   pos;
  logic            we;
  logic [AW-1:0]   waddr;
  logic            re;
  logic [AW-1:0]   raddr;
  logic            dump_done;
  dump_cmd_t       cmd;

  assign in_ready = (phase_r != PH_DUMP);
  assign acc = in_valid && in_ready;
  assign b = in_rx_byte;
  assign pos = AW'(HDR_BYTES) + pcnt_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_WAIT_AA: if (acc && b == HDR_FIRST) phase_nxt = PH_WAIT_AF;
      PH_WAIT_AF: if (acc && b == HDR_SECOND) phase_nxt = PH_WAIT_FUNC;
      PH_WAIT_FUNC: if (acc && b != 8'd0 && b < FUNC_LIMIT) phase_nxt = PH_WAIT_LEN;
      PH_WAIT_LEN: begin
        if (acc && b <= 8'(MAX_PAYLOAD)) begin
          phase_nxt = (b == 8'd0) ? PH_TRAILER : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: if (acc && rem_nxt == '0) phase_nxt = PH_TRAILER;
      PH_TRAILER: if (acc) phase_nxt = PH_DUMP;
      PH_DUMP: if (dump_done) phase_nxt = PH_WAIT_AA;
      default: phase_nxt = PH_WAIT_AA;
    endcase
  end

  // store writes, counters and readout start
  always_comb begin
    we = 1'b0;
    waddr = '0;
    rem_nxt = rem_r;
    pcnt_nxt = pcnt_r;
    cmd.go = 1'b0;
    cmd.last_idx = IDX_W'(pos);
    unique case (phase_r)
      PH_WAIT_AA: begin
        we = acc && b == HDR_FIRST;
        waddr = AW'(0);
      end
      PH_WAIT_AF: begin
        we = acc && b == HDR_SECOND;
        waddr = AW'(1);
      end
      PH_WAIT_FUNC: begin
        we = acc && b != 8'd0 && b < FUNC_LIMIT;
        waddr = AW'(2);
      end
      PH_WAIT_LEN: begin
        we = acc && b <= 8'(MAX_PAYLOAD);
        waddr = AW'(3);
        if (we) begin
          rem_nxt = b[AW-1:0];
          pcnt_nxt = '0;
        end
      end
      PH_PAYLOAD: begin
        we = acc;
        waddr = pos;
        rem_nxt = (rem_r != '0) ? rem_r - AW'(1) : rem_r;
        if (acc) begin
          if (pcnt_r < AW'(MAX_PAYLOAD)) pcnt_nxt = pcnt_r + AW'(1);
        end else begin
          rem_nxt = rem_r;
        end
      end
      PH_TRAILER: begin
        we = acc;
        waddr = pos;
        cmd.go = acc;
      end
      PH_DUMP: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_AA;
      rem_r <= '0;
      pcnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r <= rem_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  sfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (b),
    .re    (re),
    .raddr (raddr),
    .rdata (out_frame_byte)
  );

  sfr_dump #(
    .AW(AW)
  ) u_dump (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .out_ready      (out_ready),
    .re             (re),
    .raddr          (raddr),
    .out_valid      (out_valid),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte),
    .done           (dump_done)
  );

endmodule
`default_nettype wire

// File: rtl/serial_frame_receiver_checker.sv
`default_nettype none
module serial_frame_receiver_checker #(
  parameter int unsigned MAX_PAYLOAD = 49
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_frame_byte,
  input wire logic [5:0] out_byte_index,
  input wire logic       out_last_byte
);

  // no input taken while a frame is being read out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during frame readout");

  // frame beats follow back to back with rising index
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_byte) |=>
      (out_valid && out_byte_index == $past(out_byte_index) + 6'd1))
    else $error("frame beat index did not advance");

  // first beat is the header byte
  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_index == 6'd0) |-> (out_frame_byte == 8'hAA))
    else $error("frame does not start with header");

  // trailer sits within the legal frame length
  a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |->
      (out_byte_index >= 6'd4 && out_byte_index <= 6'(MAX_PAYLOAD + 4)))
    else $error("trailer index out of range");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_frame_byte) && $stable(out_byte_index)
       && $stable(out_last_byte)))
    else $error("stalled output beat changed");

endmodule

bind serial_frame_receiver serial_frame_receiver_checker #(
  .MAX_PAYLOAD(MAX_PAYLOAD)
) u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_byte (out_frame_byte),
  .out_byte_index (out_byte_index),
  .out_last_byte  (out_last_byte)
);
`default_nettype wire
